// ===== hdl/btrem_pkg.sv =====
// Package for the beat-synced tremolo: widths, register indexes and the
// command/status bundles between controller and datapath. No dependencies.
package btrem_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int PHASE_BITS  = 16;

   localparam int ACC_BITS   = 48;
   localparam int DEPTH_BITS = 17;
   localparam int RATE_BITS  = 12;
   localparam int STEP_BITS  = 32;
   localparam int GAIN_BITS  = 17;
   localparam int U_BITS     = 32;
   localparam int DEN_BITS   = 35;
   localparam int SINE_BITS  = 17;

   localparam logic [DEPTH_BITS-1:0] UNITY = DEPTH_BITS'(65536);
   localparam logic [GAIN_BITS-1:0]  MID   = GAIN_BITS'(32768);

   // dividend (acc << 8) bits 55 down to 32-PHASE_BITS
   localparam int DIV1_LSB   = 24 - PHASE_BITS;
   localparam int DIV1_STEPS = ACC_BITS - DIV1_LSB;
   localparam int DIV2_STEPS = SINE_BITS;
   localparam int CNT_BITS   = $clog2(DIV1_STEPS);

   localparam logic [DEPTH_BITS-1:0] DEPTH_RST = DEPTH_BITS'(32768);
   localparam logic [RATE_BITS-1:0]  RATE_RST  = RATE_BITS'(256);
   localparam logic [STEP_BITS-1:0]  STEP_RST  = STEP_BITS'(178957);

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEPTH = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RATE  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP  = 2'd2;

   typedef struct packed {
      logic capture;
      logic div1_step;
      logic sine;
      logic prep;
      logic div2_step;
      logic gain_mul;
      logic gain_fin;
      logic mul_left;
      logic mul_right;
      logic finish;
   } btrem_cmd_type;

   typedef struct packed {
      logic div1_last;
      logic div2_last;
   } btrem_sts_type;

endpackage

// ===== hdl/btrem_ctrl.sv =====
// Sequencer for the tremolo: walks each sample pair through the datapath
// steps and owns both handshakes. Depends on btrem_pkg.
module btrem_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  btrem_pkg::btrem_sts_type sts,
   output btrem_pkg::btrem_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV1, ST_SINE, ST_PREP, ST_DIV2,
      ST_GAIN_MUL, ST_GAIN_FIN, ST_MUL_L, ST_MUL_R, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = ST_DIV1;
         end
         ST_DIV1: begin
            cmd.div1_step = 1'b1;
            if (sts.div1_last) state_in = ST_SINE;
         end
         ST_SINE: begin
            cmd.sine = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.div2_step = 1'b1;
            if (sts.div2_last) state_in = ST_GAIN_MUL;
         end
         ST_GAIN_MUL: begin
            cmd.gain_mul = 1'b1;
            state_in = ST_GAIN_FIN;
         end
         ST_GAIN_FIN: begin
            cmd.gain_fin = 1'b1;
            state_in = ST_MUL_L;
         end
         ST_MUL_L: begin
            cmd.mul_left = 1'b1;
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            cmd.mul_right = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            cmd.finish = !rsp_valid_ff || rsp_ready;
            if (cmd.finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/btrem_dp.sv =====
// Datapath for the tremolo: control registers, beat accumulator, phase and
// sine dividers, gain and sample multipliers, output register. Uses btrem_pkg.
module btrem_dp (
   input  logic                                         clock,
   input  logic                                         reset,
   input  btrem_pkg::btrem_cmd_type                     cmd,
   output btrem_pkg::btrem_sts_type                     sts,
   input  logic                                         csr_valid,
   input  logic [btrem_pkg::CSR_IDX_BITS-1:0]           csr_index,
   input  logic [btrem_pkg::STEP_BITS-1:0]              csr_data,
   input  logic signed [btrem_pkg::SAMPLE_BITS-1:0]     req_left_in,
   input  logic signed [btrem_pkg::SAMPLE_BITS-1:0]     req_right_in,
   input  logic                                         req_load_beat,
   input  logic [btrem_pkg::ACC_BITS-1:0]               req_beat_position,
   output logic signed [btrem_pkg::SAMPLE_BITS-1:0]     rsp_left_out,
   output logic signed [btrem_pkg::SAMPLE_BITS-1:0]     rsp_right_out
);

   localparam int SB  = btrem_pkg::SAMPLE_BITS;
   localparam int PB  = btrem_pkg::PHASE_BITS;
   localparam int D1  = btrem_pkg::DIV1_STEPS;
   localparam int RB  = btrem_pkg::RATE_BITS;
   localparam int DB  = btrem_pkg::DEN_BITS;
   localparam int GB  = btrem_pkg::GAIN_BITS;
   localparam int NB  = btrem_pkg::DEPTH_BITS;
   localparam int UB  = btrem_pkg::U_BITS;
   localparam int CB  = btrem_pkg::CNT_BITS;
   localparam int MB  = SB + GB + 1;

   logic [NB-1:0]                      depth_ff;
   logic [RB-1:0]                      rate_ff;
   logic [btrem_pkg::STEP_BITS-1:0]    step_ff;
   logic [btrem_pkg::ACC_BITS-1:0]     acc_ff;
   logic signed [SB-1:0]               left_ff, right_ff;
   logic [D1-1:0]                      quo_ff;
   logic [RB-1:0]                      rem1_ff;
   logic [UB-1:0]                      u_ff;
   logic [DB-1:0]                      rem2_ff, den_ff;
   logic [btrem_pkg::SINE_BITS-1:0]    s_ff;
   logic [2*NB-1:0]                    gprod_ff;
   logic [GB-1:0]                      gain_ff;
   logic signed [SB-1:0]               res_l_ff, res_r_ff;
   logic signed [SB-1:0]               out_l_ff, out_r_ff;
   logic [CB-1:0]                      cnt_ff;

   logic [btrem_pkg::ACC_BITS-1:0]     acc_src;
   logic [RB-1:0]                      rate_eff;
   logic [RB:0]                        trial1;
   logic                               bit1;
   logic [PB-1:0]                      phase;
   logic [23:0]                        t24;
   logic [24:0]                        tc25;
   logic [48:0]                        uprod;
   logic [DB:0]                        trial2;
   logic                               bit2;
   logic [GB-1:0]                      lfo, lfo_gap;
   logic [NB-1:0]                      d_sat;
   logic signed [SB-1:0]               mul_src;
   logic signed [MB-1:0]               mprod;

   assign rsp_left_out  = out_l_ff;
   assign rsp_right_out = out_r_ff;

   assign sts.div1_last = (cnt_ff == CB'(D1 - 1));
   assign sts.div2_last = (cnt_ff == CB'(btrem_pkg::DIV2_STEPS - 1));

   assign acc_src  = req_load_beat ? req_beat_position : acc_ff;
   assign rate_eff = (rate_ff == '0) ? RB'(1) : rate_ff;

   // phase divider: one quotient bit of (acc << 8) / rate per step
   assign trial1 = {rem1_ff, quo_ff[D1-1]};
   assign bit1   = (trial1 >= {1'b0, rate_eff});
   assign phase  = quo_ff[PB-1:0];

   // t = 2p mod 1 widened to Q0.24, u = t*(1-t)
   assign t24   = 24'({phase[PB-2:0], 1'b0}) << (24 - PB);
   assign tc25  = 25'(1 << 24) - {1'b0, t24};
   assign uprod = {25'd0, t24} * {24'd0, tc25};

   // sine divider: 16u*2^16 / (5*2^32 - 4u), remainder starts at 8u
   assign trial2 = {rem2_ff, 1'b0};
   assign bit2   = (trial2 >= {1'b0, den_ff});

   assign lfo     = phase[PB-1] ? (btrem_pkg::MID - GB'(s_ff[16:1]))
                                : (btrem_pkg::MID + GB'(s_ff[16:1]));
   assign lfo_gap = btrem_pkg::UNITY - lfo;
   assign d_sat   = (depth_ff > btrem_pkg::UNITY) ? btrem_pkg::UNITY : depth_ff;

   assign mul_src = cmd.mul_right ? right_ff : left_ff;
   assign mprod   = MB'(mul_src) * $signed({1'b0, gain_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= btrem_pkg::DEPTH_RST;
         rate_ff  <= btrem_pkg::RATE_RST;
         step_ff  <= btrem_pkg::STEP_RST;
         acc_ff   <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               btrem_pkg::CSR_DEPTH: depth_ff <= csr_data[NB-1:0];
               btrem_pkg::CSR_RATE:  rate_ff  <= csr_data[RB-1:0];
               btrem_pkg::CSR_STEP:  step_ff  <= csr_data;
               default: ;
            endcase
         end
         if (cmd.capture) acc_ff <= acc_src;
         else if (cmd.finish) acc_ff <= acc_ff + btrem_pkg::ACC_BITS'(step_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         left_ff  <= req_left_in;
         right_ff <= req_right_in;
         quo_ff   <= acc_src[btrem_pkg::ACC_BITS-1:btrem_pkg::DIV1_LSB];
         rem1_ff  <= '0;
         cnt_ff   <= '0;
      end
      if (cmd.div1_step) begin
         rem1_ff <= bit1 ? RB'(trial1 - {1'b0, rate_eff}) : trial1[RB-1:0];
         quo_ff  <= {quo_ff[D1-2:0], bit1};
         cnt_ff  <= cnt_ff + CB'(1);
      end
      if (cmd.sine) begin
         u_ff   <= uprod[UB+15:16];
         cnt_ff <= '0;
      end
      if (cmd.prep) begin
         rem2_ff <= DB'(u_ff) << 3;
         den_ff  <= (DB'(5) << 32) - (DB'(u_ff) << 2);
      end
      if (cmd.div2_step) begin
         rem2_ff <= bit2 ? DB'(trial2 - {1'b0, den_ff}) : trial2[DB-1:0];
         s_ff    <= {s_ff[15:0], bit2};
         cnt_ff  <= cnt_ff + CB'(1);
      end
      if (cmd.gain_mul) gprod_ff <= d_sat * NB'(lfo_gap);
      if (cmd.gain_fin) gain_ff <= btrem_pkg::UNITY - GB'(gprod_ff[2*NB-1:16]);
      if (cmd.mul_left)  res_l_ff <= mprod[SB+15:16];
      if (cmd.mul_right) res_r_ff <= mprod[SB+15:16];
      if (cmd.finish) begin
         out_l_ff <= res_l_ff;
         out_r_ff <= res_r_ff;
      end
   end

endmodule

// ===== hdl/beat_synced_tremolo.sv =====
// Channel   Handshake              Payload
// req       req_valid/req_ready    left_in, right_in, load_beat, beat_position
// rsp       rsp_valid/rsp_ready    left_out, right_out
// csr       csr_valid/csr_ready    csr_index (2b), csr_data (32b)
//
// Per sample pair: capture, 40 steps of the restoring phase divider, 17
// steps of the sine divider, then multiply and output; no new pair is
// taken meanwhile. Synchronous active-high reset; csr_ready is always high.
// A result held by rsp_ready low does not block the next input transfer;
// the following result waits in its last step until the output frees up.
// Top level: joins btrem_ctrl and btrem_dp; uses btrem_pkg.
module beat_synced_tremolo (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [btrem_pkg::SAMPLE_BITS-1:0] req_left_in,
   input  logic signed [btrem_pkg::SAMPLE_BITS-1:0] req_right_in,
   input  logic                                     req_load_beat,
   input  logic [btrem_pkg::ACC_BITS-1:0]           req_beat_position,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [btrem_pkg::SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [btrem_pkg::SAMPLE_BITS-1:0] rsp_right_out,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [btrem_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [btrem_pkg::STEP_BITS-1:0]          csr_data
);

   btrem_pkg::btrem_cmd_type cmd;
   btrem_pkg::btrem_sts_type sts;

   assign csr_ready = 1'b1;

   btrem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   btrem_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_left_in       (req_left_in),
      .req_right_in      (req_right_in),
      .req_load_beat     (req_load_beat),
      .req_beat_position (req_beat_position),
      .rsp_left_out      (rsp_left_out),
      .rsp_right_out     (rsp_right_out)
   );

endmodule

// ===== hdl/btrem_chk.sv =====
// Port-level checks for beat_synced_tremolo, bound to the top level.
// Depends on btrem_pkg for payload widths.
module btrem_chk (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_ready,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic signed [btrem_pkg::SAMPLE_BITS-1:0] rsp_left_out,
   input logic signed [btrem_pkg::SAMPLE_BITS-1:0] rsp_right_out
);

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out))
      else $error("rsp payload changed while stalled");

   // after an input transfer the block is busy and takes no further input
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("input taken again too early");

   // a new result only appears at the end of the busy phase
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while idle");

endmodule

bind beat_synced_tremolo btrem_chk u_chk (.*);
